FILE: rtl/msde_pkg.sv
// Package for the mean and standard deviation unit: widths, states, commands.
// Used by all modules in rtl/.
`timescale 1ns / 1ps
package msde_pkg;
    localparam int SAMPLE_W = 16;
    localparam int DEF_MAX_SAMPLES = 256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_RD_FIRST,
        ST_ACCUM,
        ST_DIV_VAR,
        ST_SQRT,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic add;
        logic clear;
        logic div_mean_start;
        logic div_var_start;
        logic rd_start;
        logic acc_step;
        logic sqrt_start;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic div_done;
        logic acc_last;
        logic sqrt_done;
    } t_status;
endpackage

FILE: rtl/mean_and_stddev_engine_unit.sv
// Top level of the mean and standard deviation unit.
// Add requests are accepted back to back while idle. A finish request runs the
// serial divider twice (mean, then variance) and then the square root; a finish
// on an empty set skips them and goes straight to the emit state. Results are
// strobed for one cycle by o_valid; the receiver cannot stall. Synchronous
// active-low reset clears count, sum, flag and control; memory needs no reset.
`timescale 1ns / 1ps
module mean_and_stddev_engine_unit #(
    parameter int MAX_SAMPLES = msde_pkg::DEF_MAX_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [15:0] i_sample,
    output logic        o_valid,
    output logic [15:0] o_mean,
    output logic [15:0] o_std_dev,
    output logic [8:0]  o_sample_count,
    output logic        o_overflowed
);
    import msde_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    msde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_operation(i_operation),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    msde_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample      (i_sample),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_mean        (o_mean),
        .o_std_dev     (o_std_dev),
        .o_sample_count(o_sample_count),
        .o_overflowed  (o_overflowed)
    );
endmodule

FILE: rtl/msde_ctrl.sv
// Controller state machine for the mean and standard deviation unit.
// Depends on msde_pkg.
`timescale 1ns / 1ps
module msde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  msde_pkg::t_status i_status,
    output msde_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import msde_pkg::*;

    t_state r_state, n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_operation) begin
                    n_state = i_status.empty ? ST_EMIT : ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: if (i_status.div_done) n_state = ST_RD_FIRST;
            ST_RD_FIRST: n_state = ST_ACCUM;
            ST_ACCUM:    if (i_status.acc_last) n_state = ST_DIV_VAR;
            ST_DIV_VAR:  if (i_status.div_done) n_state = ST_SQRT;
            ST_SQRT:     if (i_status.sqrt_done) n_state = ST_EMIT;
            ST_EMIT:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.add = i_start && !i_operation;
                o_cmd.div_mean_start = i_start && i_operation && !i_status.empty;
            end
            ST_DIV_MEAN: o_cmd.rd_start = i_status.div_done;
            ST_RD_FIRST: o_cmd.acc_step = 1'b0;
            ST_ACCUM: begin
                o_cmd.acc_step = 1'b1;
                o_cmd.div_var_start = i_status.acc_last;
            end
            ST_DIV_VAR: o_cmd.sqrt_start = i_status.div_done;
            ST_SQRT: o_cmd.acc_step = 1'b0;
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.clear = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end
endmodule

FILE: rtl/msde_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on msde_pkg (file convention only).
`timescale 1ns / 1ps
module msde_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_done
);
    import msde_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};

    // Shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CNT_W'(NUM_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

FILE: rtl/msde_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Depends on msde_pkg (file convention only).
`timescale 1ns / 1ps
module msde_sqrt #(
    parameter int IN_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [IN_W-1:0]   i_val,
    output logic [IN_W/2-1:0] o_root,
    output logic              o_done
);
    import msde_pkg::*;
    localparam int R_W   = IN_W / 2;
    localparam int CNT_W = $clog2(R_W + 1);

    logic [IN_W-1:0]  r_val;
    logic [R_W+1:0]   r_rem;
    logic [R_W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [R_W+1:0]   w_trial;
    logic [R_W+1:0]   w_test;

    assign w_trial = {r_rem[R_W-1:0], r_val[IN_W-1 -: 2]};
    assign w_test  = {r_root, 2'b01};

    // Resolve one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(R_W);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_val <= {r_val[IN_W-3:0], 2'b00};
                if (w_trial >= w_test) begin
                    r_rem  <= w_trial - w_test;
                    r_root <= {r_root[R_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_root <= {r_root[R_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

FILE: rtl/msde_datapath.sv
// Datapath: sample memory, running sum, deviation accumulator, divider, root.
// Depends on msde_pkg, msde_div, msde_sqrt.
`timescale 1ns / 1ps
module msde_datapath #(
    parameter int MAX_SAMPLES = msde_pkg::DEF_MAX_SAMPLES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  msde_pkg::t_cmd             i_cmd,
    input  logic [msde_pkg::SAMPLE_W-1:0] i_sample,
    output msde_pkg::t_status          o_status,
    output logic                       o_valid,
    output logic [msde_pkg::SAMPLE_W-1:0] o_mean,
    output logic [msde_pkg::SAMPLE_W-1:0] o_std_dev,
    output logic [8:0]                 o_sample_count,
    output logic                       o_overflowed
);
    import msde_pkg::*;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int ADR_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_W + CNT_W;
    localparam int DV_W  = (SQ_W % 2 == 0) ? SQ_W : SQ_W + 1;

    logic [SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic                r_drop;
    logic [ADR_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_left;
    logic [SAMPLE_W-1:0] r_mean;
    logic [SQ_W-1:0]     r_sq;
    logic [SAMPLE_W-1:0] r_dev;
    logic                r_dev_v;
    logic [2*SAMPLE_W-1:0] r_prod;
    logic                r_prod_v;
    logic                r_var_go;
    logic                r_sel_var;
    logic [SAMPLE_W-1:0] r_root;
    logic                r_valid;
    logic [SAMPLE_W-1:0] r_omean;
    logic [SAMPLE_W-1:0] r_ostd;
    logic [8:0]          r_ocnt;
    logic                r_oflow;

    logic [DV_W-1:0]     w_num;
    logic [DV_W-1:0]     w_quot;
    logic                w_div_done;
    logic [DV_W/2-1:0]   w_root;
    logic                w_sqrt_done;
    logic                w_full;
    logic [ADR_W-1:0]    w_rd_addr;

    assign w_full = (r_count == CNT_W'(MAX_SAMPLES));

    // Prefetch the next entry while the walk steps
    assign w_rd_addr = (i_cmd.acc_step && (r_left != '0)) ? r_addr + 1'b1 : r_addr;

    // Store samples
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !w_full) r_mem[r_count[ADR_W-1:0]] <= i_sample;
        r_rd <= r_mem[w_rd_addr];
    end

    // Keep sum, count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.add) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(i_sample);
            end
        end
    end

    // Divider operand select
    assign w_num = r_sel_var ? DV_W'(r_sq) : DV_W'(r_sum);

    msde_div #(.NUM_W(DV_W), .DEN_W(CNT_W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.div_mean_start || r_var_go),
        .i_num  (w_num),
        .i_den  (r_count),
        .o_quot (w_quot),
        .o_done (w_div_done)
    );

    msde_sqrt #(.IN_W(DV_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.sqrt_start),
        .i_val  (w_quot),
        .o_root (w_root),
        .o_done (w_sqrt_done)
    );

    // Walk the buffer: read, deviation, square, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_v   <= 1'b0;
            r_prod_v  <= 1'b0;
            r_var_go  <= 1'b0;
            r_sel_var <= 1'b0;
            r_left    <= '0;
            r_addr    <= '0;
        end else begin
            r_var_go <= 1'b0;
            // Select the sum again at a mean division start or once the set is done
            if (i_cmd.div_mean_start || i_cmd.clear) r_sel_var <= 1'b0;
            if (i_cmd.rd_start) begin
                r_mean <= w_quot[SAMPLE_W-1:0];
                r_addr <= '0;
                r_left <= r_count;
                r_sq   <= '0;
            end
            r_dev_v <= i_cmd.acc_step && (r_left != '0);
            if (i_cmd.acc_step && (r_left != '0)) begin
                r_left <= r_left - 1'b1;
                r_addr <= r_addr + 1'b1;
                r_dev  <= (r_rd >= r_mean) ? r_rd - r_mean : r_mean - r_rd;
            end
            r_prod_v <= r_dev_v;
            if (r_dev_v) r_prod <= r_dev * r_dev;
            if (r_prod_v) r_sq <= r_sq + SQ_W'(r_prod);
            if (i_cmd.div_var_start) begin
                r_var_go  <= 1'b1;
                r_sel_var <= 1'b1;
            end
            if (w_sqrt_done) r_root <= w_root[SAMPLE_W-1:0];
        end
    end

    assign o_status.empty     = (r_count == '0);
    assign o_status.div_done  = w_div_done;
    assign o_status.acc_last  = (r_left == '0) && !r_dev_v && !r_prod_v;
    assign o_status.sqrt_done = w_sqrt_done;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_omean <= (r_count == '0) ? '0 : r_mean;
                r_ostd  <= (r_count == '0) ? '0 : r_root;
                r_ocnt  <= 9'(r_count);
                r_oflow <= (r_count == '0) ? 1'b0 : r_drop;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_mean         = r_omean;
    assign o_std_dev      = r_ostd;
    assign o_sample_count = r_ocnt;
    assign o_overflowed   = r_oflow;
endmodule

FILE: dv/tb_mean_and_stddev_engine_unit.sv
// Testbench for mean_and_stddev_engine_unit: drives add and finish requests
// with random gaps and checks each strobed result against an internal predictor.
// Depends on rtl/msde_pkg.sv and rtl/mean_and_stddev_engine_unit.sv.
`timescale 1ns / 1ps

class stats_scoreboard;
    localparam int CAP = msde_pkg::DEF_MAX_SAMPLES;

    bit [15:0] kept_samples[CAP];
    int unsigned kept_n;
    longint unsigned sum_acc;
    bit dropped;
    bit [41:0] pending_stats[$];
    int errors;

    function new();
        kept_n = 0;
        sum_acc = 0;
        dropped = 0;
        errors = 0;
    endfunction

    // Floor square root, one result bit per pass
    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int b;
        root = 0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // Note an accepted request; a finish queues the expected statistics
    function void note_request(bit op, bit [15:0] s);
        longint unsigned avg;
        longint unsigned sq;
        longint unsigned d;
        longint unsigned sd;
        int i;
        if (op == 1'b0) begin
            if (kept_n < CAP) begin
                kept_samples[kept_n] = s;
                kept_n++;
                sum_acc += s;
            end else begin
                dropped = 1;
            end
            return;
        end
        avg = 0;
        sd = 0;
        if (kept_n != 0) begin
            avg = sum_acc / kept_n;
            sq = 0;
            for (i = 0; i < kept_n; i++) begin
                d = (kept_samples[i] >= avg) ? kept_samples[i] - avg : avg - kept_samples[i];
                sq += d * d;
            end
            sd = floor_sqrt(sq / kept_n);
        end
        pending_stats.push_back({avg[15:0], sd[15:0], kept_n[8:0], dropped});
        kept_n = 0;
        sum_acc = 0;
        dropped = 0;
    endfunction

    // Compare one strobed result with the oldest expectation
    function void check_result(bit [15:0] m, bit [15:0] sd, bit [8:0] n, bit ov);
        bit [41:0] exp_v;
        if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result mean=%0d std=%0d n=%0d ov=%0d",
                     $time, m, sd, n, ov);
            errors++;
            return;
        end
        exp_v = pending_stats.pop_front();
        if (exp_v[41:26] != m) begin
            $display("%0t: mean expected %0d actual %0d", $time, exp_v[41:26], m);
            errors++;
        end
        if (exp_v[25:10] != sd) begin
            $display("%0t: std_dev expected %0d actual %0d", $time, exp_v[25:10], sd);
            errors++;
        end
        if (exp_v[9:1] != n) begin
            $display("%0t: sample_count expected %0d actual %0d", $time, exp_v[9:1], n);
            errors++;
        end
        if (exp_v[0] != ov) begin
            $display("%0t: overflowed expected %0d actual %0d", $time, exp_v[0], ov);
            errors++;
        end
    endfunction
endclass

module tb_mean_and_stddev_engine_unit;
    localparam int CAP = msde_pkg::DEF_MAX_SAMPLES;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [15:0] i_sample;
    logic        o_valid;
    logic [15:0] o_mean;
    logic [15:0] o_std_dev;
    logic [8:0]  o_sample_count;
    logic        o_overflowed;

    stats_scoreboard stats_sb;
    int idle_cycles;

    mean_and_stddev_engine_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .o_mean         (o_mean),
        .o_std_dev      (o_std_dev),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check results and count cycles with no progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) stats_sb.check_result(o_mean, o_std_dev, o_sample_count, o_overflowed);
            if (o_valid || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Mostly short gaps, sometimes long ones; drop start only for a real gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until accepted
    task automatic send_request(bit op, bit [15:0] s);
        start <= 1'b1;
        i_operation <= op;
        i_sample <= s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        stats_sb.note_request(op, s);
        idle_gap();
    endtask

    task automatic add_random_set(int n, bit [15:0] lo, bit [15:0] hi);
        repeat (n) send_request(1'b0, 16'($urandom_range(lo, hi)));
    endtask

    int sent;
    int n;

    initial begin
        stats_sb = new();
        idle_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = 1'b0;
        i_sample = 16'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b0 + 1'b1;

        // Directed: empty set, single sample, extremes, constant set
        send_request(1'b1, 16'd0);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b1, 16'd0);
        send_request(1'b0, 16'd0);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b1, 16'hFFFF);
        send_request(1'b0, 16'h5555);
        send_request(1'b0, 16'hAAAA);
        send_request(1'b0, 16'h0001);
        send_request(1'b1, 16'h1234);
        send_request(1'b0, 16'd7);
        send_request(1'b0, 16'd7);
        send_request(1'b1, 16'd0);
        // Fill past capacity with extremes so the flag is set
        for (int i = 0; i < CAP + 3; i++) send_request(1'b0, (i % 2) ? 16'hFFFF : 16'd0);
        send_request(1'b1, 16'd0);
        send_request(1'b1, 16'd0);

        // Random sets, mostly small, a few full
        sent = 0;
        while (sent < 320) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(CAP - 2, CAP + 4);
                1: n = 0;
                default: n = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 1)) add_random_set(n, 16'd0, 16'hFFFF);
            else add_random_set(n, 16'd1000, 16'd1100);
            send_request(1'b1, 16'($urandom));
            sent += n + 1;
        end
        start <= 1'b0;

        // Drain outstanding results, then allow the tail latency
        while (stats_sb.pending_stats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (stats_sb.errors == 0 && stats_sb.pending_stats.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/msde_pkg.sv
rtl/msde_ctrl.sv
rtl/msde_div.sv
rtl/msde_sqrt.sv
rtl/msde_datapath.sv
rtl/mean_and_stddev_engine_unit.sv
dv/tb_mean_and_stddev_engine_unit.sv
